### src/jsu_pkg.sv
package jsu_pkg;

	localparam int MAX_BURST = 5;

	localparam logic [7:0] BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;

	localparam logic [23:0] EXT_LOW  = 24'h01F300;
	localparam logic [23:0] EXT_HIGH = 24'h01F64F;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ESC,
		PH_HEX
	} phase_t;

	typedef struct packed {
		logic [2:0]      n;
		logic [3:0][7:0] b;
	} utf8_t;

	typedef struct packed {
		logic [2:0]                n;
		logic [MAX_BURST-1:0][7:0] bytes;
	} burst_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] ch;
	} esc_t;

	typedef struct packed {
		logic full;
		logic avail;
	} qstat_t;

	localparam utf8_t UTF8_NONE = '{n: 3'd0, b: '0};

	function automatic logic [3:0] nibble(input logic [7:0] c);
		logic [7:0] d;
		begin
			if (c >= 8'h61)
				d = c - 8'h57;
			else if (c >= 8'h41)
				d = c - 8'h37;
			else if (c >= 8'h30)
				d = c - 8'h30;
			else
				d = c;
			return d[3:0];
		end
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic esc_t map_escape(input logic [7:0] c);
		esc_t r;
		begin
			r.hit = 1'b1;
			r.ch  = c;
			case (c)
				8'h30: r.ch = 8'h00;
				8'h6E: r.ch = 8'h0A;
				8'h72: r.ch = 8'h0D;
				8'h74: r.ch = 8'h09;
				8'h76: r.ch = 8'h0B;
				8'h61: r.ch = 8'h07;
				8'h62: r.ch = 8'h08;
				8'h66: r.ch = 8'h0C;
				8'h27, 8'h22, 8'h5C, 8'h2F: r.ch = c;
				default: r.hit = 1'b0;
			endcase
			return r;
		end
	endfunction

	function automatic utf8_t utf8_enc(input logic [20:0] v);
		utf8_t r;
		begin
			r.b = '0;
			if (v <= 21'h7F) begin
				r.n    = 3'd1;
				r.b[0] = v[7:0];
			end else if (v <= 21'h7FF) begin
				r.n    = 3'd2;
				r.b[0] = {3'b110, v[10:6]};
				r.b[1] = {2'b10, v[5:0]};
			end else if (v <= 21'hFFFF) begin
				r.n    = 3'd3;
				r.b[0] = {4'b1110, v[15:12]};
				r.b[1] = {2'b10, v[11:6]};
				r.b[2] = {2'b10, v[5:0]};
			end else begin
				r.n    = 3'd4;
				r.b[0] = {5'b11110, v[20:18]};
				r.b[1] = {2'b10, v[17:12]};
				r.b[2] = {2'b10, v[11:6]};
				r.b[3] = {2'b10, v[5:0]};
			end
			return r;
		end
	endfunction

	// encoded prefix, then up to two plain bytes
	function automatic burst_t append2(input utf8_t e, input logic [7:0] x, input logic hx,
		input logic [7:0] y, input logic hy);
		burst_t     r;
		logic [2:0] p;
		begin
			r.bytes = {8'h00, e.b};
			p       = e.n;
			if (hx) begin
				if (p < 3'(MAX_BURST))
					r.bytes[p] = x;
				p = p + 3'd1;
			end
			if (hy) begin
				if (p < 3'(MAX_BURST))
					r.bytes[p] = y;
				p = p + 3'd1;
			end
			r.n = p;
			return r;
		end
	endfunction

endpackage

### src/jsu_ifs.sv
interface jsu_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source(output valid, in_byte, in_last, input ready);
	modport sink(input valid, in_byte, in_last, output ready);
endinterface

interface jsu_utf8_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source(output valid, out_byte, out_last, input ready);
	modport sink(input valid, out_byte, out_last, output ready);
endinterface

interface jsu_cfg_if;
	logic valid;
	logic ready;
	logic unicode_escapes;

	modport source(output valid, unicode_escapes, input ready);
	modport sink(input valid, unicode_escapes, output ready);
endinterface

### src/jsu_front.sv
module jsu_front (
	input  logic             clk,
	input  logic             arst_n,
	jsu_text_if.sink         text,
	input  logic             uni,
	input  jsu_pkg::qstat_t  qstat,
	output logic             push,
	output jsu_pkg::burst_t  burst
);

	jsu_pkg::phase_t phase_q, phase_d;
	logic [2:0]      count_q, count_d;
	logic [7:0]      held_q [jsu_pkg::MAX_BURST];

	logic [7:0]      cur_byte;
	logic            last;
	logic            take;
	logic            bs;
	logic            keep_b;
	logic            hexb;
	logic [7:0]      c3;
	logic [15:0]     code16;
	logic [23:0]     v24;
	logic            ext;
	jsu_pkg::utf8_t  enc16;
	jsu_pkg::utf8_t  enc24;
	jsu_pkg::esc_t   m;

	assign text.ready = !qstat.full;
	assign take       = text.valid && !qstat.full;
	assign cur_byte   = text.in_byte;
	assign last       = text.in_last;
	assign bs         = (cur_byte == jsu_pkg::BACKSLASH);
	assign keep_b     = !(bs && !last);
	assign hexb       = jsu_pkg::is_hex(cur_byte);
	assign c3         = (count_q == 3'd3) ? cur_byte : held_q[3];
	assign code16     = {jsu_pkg::nibble(held_q[0]), jsu_pkg::nibble(held_q[1]),
		jsu_pkg::nibble(held_q[2]), jsu_pkg::nibble(c3)};
	assign v24        = {code16, jsu_pkg::nibble(held_q[4]), jsu_pkg::nibble(cur_byte)};
	assign ext        = hexb && (v24 >= jsu_pkg::EXT_LOW) && (v24 <= jsu_pkg::EXT_HIGH);
	assign enc16      = jsu_pkg::utf8_enc({5'd0, code16});
	assign enc24      = jsu_pkg::utf8_enc(v24[20:0]);
	assign m          = jsu_pkg::map_escape(cur_byte);
	assign push       = take && (burst.n != 3'd0);

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		if (take) begin
			case (phase_q)
				jsu_pkg::PH_IDLE: begin
					phase_d = (bs && !last) ? jsu_pkg::PH_ESC : jsu_pkg::PH_IDLE;
				end
				jsu_pkg::PH_ESC: begin
					if (uni && cur_byte == jsu_pkg::CH_U && !last) begin
						phase_d = jsu_pkg::PH_HEX;
						count_d = 3'd0;
					end else begin
						phase_d = jsu_pkg::PH_IDLE;
					end
				end
				jsu_pkg::PH_HEX: begin
					if (count_q >= 3'd5) begin
						count_d = 3'd0;
						phase_d = (bs && !last) ? jsu_pkg::PH_ESC : jsu_pkg::PH_IDLE;
					end else begin
						count_d = count_q + 3'd1;
						if (count_q == 3'd4 && !hexb) begin
							count_d = 3'd0;
							phase_d = (bs && !last) ? jsu_pkg::PH_ESC : jsu_pkg::PH_IDLE;
						end
					end
				end
				default: begin
					phase_d = jsu_pkg::PH_IDLE;
					count_d = 3'd0;
				end
			endcase
			if (last) begin
				phase_d = jsu_pkg::PH_IDLE;
				count_d = 3'd0;
			end
		end
	end

	always_comb begin
		burst = '0;
		case (phase_q)
			jsu_pkg::PH_IDLE: begin
				burst = jsu_pkg::append2(jsu_pkg::UTF8_NONE, cur_byte, keep_b, 8'h00, 1'b0);
			end
			jsu_pkg::PH_ESC: begin
				if (uni && cur_byte == jsu_pkg::CH_U)
					burst = '0;
				else if (m.hit)
					burst = jsu_pkg::append2(jsu_pkg::UTF8_NONE, m.ch, 1'b1, 8'h00, 1'b0);
				else
					burst = jsu_pkg::append2(jsu_pkg::UTF8_NONE, jsu_pkg::BACKSLASH, 1'b1,
						cur_byte, 1'b1);
			end
			jsu_pkg::PH_HEX: begin
				case (count_q)
					3'd1: begin
						if (last)
							burst = jsu_pkg::append2(jsu_pkg::UTF8_NONE, cur_byte, 1'b1,
								8'h00, 1'b0);
					end
					3'd2: begin
						// short escape: second held char and this one run again as text
						if (last) begin
							if (held_q[1] != jsu_pkg::BACKSLASH)
								burst = jsu_pkg::append2(jsu_pkg::UTF8_NONE, held_q[1], 1'b1,
									cur_byte, 1'b1);
							else if (uni && cur_byte == jsu_pkg::CH_U)
								burst = '0;
							else if (m.hit)
								burst = jsu_pkg::append2(jsu_pkg::UTF8_NONE, m.ch, 1'b1,
									8'h00, 1'b0);
							else
								burst = jsu_pkg::append2(jsu_pkg::UTF8_NONE,
									jsu_pkg::BACKSLASH, 1'b1, cur_byte, 1'b1);
						end
					end
					3'd3: begin
						if (last)
							burst = jsu_pkg::append2(enc16, 8'h00, 1'b0, 8'h00, 1'b0);
					end
					3'd4: begin
						if (last || !hexb)
							burst = jsu_pkg::append2(enc16, cur_byte, keep_b, 8'h00, 1'b0);
					end
					3'd5: begin
						if (ext)
							burst = jsu_pkg::append2(enc24, 8'h00, 1'b0, 8'h00, 1'b0);
						else
							burst = jsu_pkg::append2(enc16, held_q[4], 1'b1, cur_byte, keep_b);
					end
					default: burst = '0;
				endcase
			end
			default: burst = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jsu_pkg::PH_IDLE;
			count_q <= 3'd0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take && phase_q == jsu_pkg::PH_HEX && count_q < 3'd5)
			held_q[count_q] <= cur_byte;
	end

endmodule

### src/jsu_queue.sv
module jsu_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jsu_pkg::burst_t  push_data,
	input  logic             pop,
	output jsu_pkg::qstat_t  qstat,
	output jsu_pkg::burst_t  head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jsu_pkg::burst_t entry_q [DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   count_q;

	assign qstat.full  = (count_q == CW'(DEPTH));
	assign qstat.avail = (count_q != '0);
	assign head        = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wptr_q] <= push_data;
	end

endmodule

### src/jsu_back.sv
module jsu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  jsu_pkg::qstat_t  qstat,
	input  jsu_pkg::burst_t  head,
	output logic             pop,
	jsu_utf8_if.source       utf8
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic [2:0] idx_q;
	logic       load;
	logic       at_end;

	assign load   = !valid_q || utf8.ready;
	assign at_end = (idx_q == head.n - 3'd1);
	assign pop    = load && qstat.avail && at_end;

	assign utf8.valid    = valid_q;
	assign utf8.out_byte = byte_q;
	assign utf8.out_last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 3'd0;
		end else if (load) begin
			valid_q <= qstat.avail;
			if (qstat.avail)
				idx_q <= at_end ? 3'd0 : idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && qstat.avail) begin
			byte_q <= head.bytes[idx_q];
			last_q <= at_end;
		end
	end

endmodule

### src/json_string_unescape_utf8_core.sv
// Channel  Dir  Payload                      Transaction
// text     in   in_byte[7:0], in_last        text.valid && text.ready
// utf8     out  out_byte[7:0], out_last      utf8.valid && utf8.ready
// cfg      in   unicode_escapes              cfg.valid && cfg.ready (ready tied high)
//
// One text byte per cycle unless the burst queue is full; each byte yields zero to five
// output bytes, drained one per cycle while utf8.ready is high from a QUEUE_DEPTH-entry
// burst queue. Sustained input rate is one byte per cycle while each byte yields at
// most one output byte and utf8 is ready. Output bytes are registered in the burst queue and then in byte_q.
// text.ready drops only when the burst queue is full; utf8 stalls back up into it.
// Reset clears parser state, queue pointers, output valid and cfg.
module json_string_unescape_utf8_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input logic          clk,
	input logic          arst_n,
	jsu_text_if.sink     text,
	jsu_utf8_if.source   utf8,
	jsu_cfg_if.sink      cfg
);

	logic            unicode_q;
	logic            push;
	logic            pop;
	jsu_pkg::burst_t burst;
	jsu_pkg::burst_t head;
	jsu_pkg::qstat_t qstat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			unicode_q <= 1'b0;
		else if (cfg.valid)
			unicode_q <= cfg.unicode_escapes;
	end

	jsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.uni    (unicode_q),
		.qstat  (qstat),
		.push   (push),
		.burst  (burst)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (burst),
		.pop       (pop),
		.qstat     (qstat),
		.head      (head)
	);

	jsu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.head   (head),
		.pop    (pop),
		.utf8   (utf8)
	);

endmodule

### src/jsu_checker.sv
module jsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       text_valid,
	input logic       text_ready,
	input logic       utf8_valid,
	input logic       utf8_ready,
	input logic [7:0] utf8_out_byte,
	input logic       utf8_out_last,
	input logic       cfg_valid,
	input logic       cfg_ready
);

	a_no_out_in_reset: assert property (@(posedge clk) !arst_n |-> !utf8_valid)
		else $error("output valid during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		utf8_valid && !utf8_ready |=> utf8_valid && $stable(utf8_out_byte) &&
		$stable(utf8_out_last))
		else $error("stalled output transaction changed");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("cfg write not taken");

	// input backpressure only comes from a full queue, so output must be pending
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_ready |-> utf8_valid)
		else $error("input stalled with no output pending");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.text_valid    (text.valid),
	.text_ready    (text.ready),
	.utf8_valid    (utf8.valid),
	.utf8_ready    (utf8.ready),
	.utf8_out_byte (utf8.out_byte),
	.utf8_out_last (utf8.out_last),
	.cfg_valid     (cfg.valid),
	.cfg_ready     (cfg.ready)
);

### sim/testbench.sv
`timescale 1ns / 1ps

class unescape_scoreboard;
	bit               uni_en = 1'b0;
	jsu_pkg::phase_t  phase = jsu_pkg::PH_IDLE;
	int               nheld = 0;
	logic [7:0]       held [5];
	logic [7:0]       burst[$];
	logic [7:0]       rework[$];
	logic [8:0]       due_bytes[$];
	int               errors = 0;

	function logic [3:0] digit_val(logic [7:0] c);
		logic [7:0] d;
		if (c >= 8'h61)
			d = c - 8'h57;
		else if (c >= 8'h41)
			d = c - 8'h37;
		else if (c >= 8'h30)
			d = c - 8'h30;
		else
			d = c;
		return d[3:0];
	endfunction

	function bit hex_digit(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function logic [15:0] code16();
		return {digit_val(held[0]), digit_val(held[1]), digit_val(held[2]),
			digit_val(held[3])};
	endfunction

	function void push_utf8(logic [20:0] v);
		if (v <= 21'h7F) begin
			burst.push_back(v[7:0]);
		end else if (v <= 21'h7FF) begin
			burst.push_back({3'b110, v[10:6]});
			burst.push_back({2'b10, v[5:0]});
		end else if (v <= 21'hFFFF) begin
			burst.push_back({4'b1110, v[15:12]});
			burst.push_back({2'b10, v[11:6]});
			burst.push_back({2'b10, v[5:0]});
		end else begin
			burst.push_back({5'b11110, v[20:18]});
			burst.push_back({2'b10, v[17:12]});
			burst.push_back({2'b10, v[11:6]});
			burst.push_back({2'b10, v[5:0]});
		end
	endfunction

	function void unescape_byte(logic [7:0] b, bit l);
		logic [23:0] v;
		case (phase)
			jsu_pkg::PH_ESC: begin
				phase = jsu_pkg::PH_IDLE;
				if (uni_en && b == jsu_pkg::CH_U) begin
					if (!l) begin
						phase = jsu_pkg::PH_HEX;
						nheld = 0;
					end
				end else begin
					case (b)
						"0": burst.push_back(8'h00);
						"n": burst.push_back(8'h0A);
						"r": burst.push_back(8'h0D);
						"t": burst.push_back(8'h09);
						"v": burst.push_back(8'h0B);
						"a": burst.push_back(8'h07);
						"b": burst.push_back(8'h08);
						"f": burst.push_back(8'h0C);
						"'", "\"", jsu_pkg::BACKSLASH, "/": burst.push_back(b);
						default: begin
							burst.push_back(jsu_pkg::BACKSLASH);
							burst.push_back(b);
						end
					endcase
				end
			end
			jsu_pkg::PH_HEX: begin
				if (nheld >= 5) begin
					// sixth digit: emoji range extension or fall back
					phase = jsu_pkg::PH_IDLE;
					nheld = 0;
					if (hex_digit(b)) begin
						v = {code16(), digit_val(held[4]), digit_val(b)};
						if (v >= jsu_pkg::EXT_LOW && v <= jsu_pkg::EXT_HIGH) begin
							push_utf8(v[20:0]);
							return;
						end
					end
					push_utf8({5'd0, code16()});
					rework.push_back(held[4]);
					rework.push_back(b);
					return;
				end
				held[nheld] = b;
				nheld++;
				if (nheld < 4) begin
					if (l) begin
						for (int k = 1; k < nheld; k++)
							rework.push_back(held[k]);
						phase = jsu_pkg::PH_IDLE;
						nheld = 0;
					end
				end else if (nheld == 4) begin
					if (l) begin
						push_utf8({5'd0, code16()});
						phase = jsu_pkg::PH_IDLE;
						nheld = 0;
					end
				end else if (l || !hex_digit(b)) begin
					push_utf8({5'd0, code16()});
					phase = jsu_pkg::PH_IDLE;
					nheld = 0;
					rework.push_back(b);
				end
			end
			default: begin
				phase = jsu_pkg::PH_IDLE;
				if (b == jsu_pkg::BACKSLASH && !l)
					phase = jsu_pkg::PH_ESC;
				else
					burst.push_back(b);
			end
		endcase
	endfunction

	function void take_text(logic [7:0] b, bit l);
		int i;
		int n;
		burst.delete();
		rework.delete();
		rework.push_back(b);
		i = 0;
		while (i < rework.size()) begin
			i++;
			unescape_byte(rework[i-1], l && i == rework.size());
		end
		if (l) begin
			phase = jsu_pkg::PH_IDLE;
			nheld = 0;
		end
		n = (burst.size() > jsu_pkg::MAX_BURST) ? jsu_pkg::MAX_BURST : burst.size();
		for (int k = 0; k < n; k++)
			due_bytes.push_back({k == n - 1, burst[k]});
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task check_utf8(logic [7:0] b, logic l);
		logic [8:0] e;
		if (due_bytes.size() == 0) begin
			report($sformatf("unexpected output byte %h last %b", b, l));
			return;
		end
		e = due_bytes.pop_front();
		if (b !== e[7:0])
			report($sformatf("out_byte %h, expected %h", b, e[7:0]));
		if (l !== e[8])
			report($sformatf("out_last %b, expected %b (byte %h)", l, e[8], e[7:0]));
	endtask
endclass

module testbench;
	localparam int    LIMIT = 300000;
	localparam string HEXCH = "0123456789abcdefABCDEF";
	localparam string ESCCH = "0nrtvabf'\"\\/";

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycles = 0;
	int   gap_pct = 0;
	int   stall_pct = 0;
	logic [7:0] str_buf[$];
	unescape_scoreboard sb;

	jsu_text_if text();
	jsu_utf8_if utf8();
	jsu_cfg_if  cfg();

	json_string_unescape_utf8_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.utf8   (utf8),
		.cfg    (cfg)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		utf8.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && utf8.valid && utf8.ready)
			sb.check_utf8(utf8.out_byte, utf8.out_last);
	end

	task automatic send_byte(input logic [7:0] b, input bit l);
		if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			text.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < gap_pct)
				@(posedge clk);
		end
		text.valid   <= 1'b1;
		text.in_byte <= b;
		text.in_last <= l;
		@(posedge clk);
		while (!text.ready)
			@(posedge clk);
		sb.take_text(b, l);
	endtask

	task automatic send_buf();
		for (int i = 0; i < str_buf.size(); i++)
			send_byte(str_buf[i], i == str_buf.size() - 1);
		str_buf.delete();
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			str_buf.push_back(s[i]);
		send_buf();
	endtask

	task automatic drain();
		text.valid <= 1'b0;
		while (sb.due_bytes.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_unicode(input bit en);
		drain();
		cfg.valid           <= 1'b1;
		cfg.unicode_escapes <= en;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		sb.uni_en = en;
	endtask

	function automatic logic [7:0] hex_of(logic [3:0] d);
		logic [7:0] base;
		base = ($urandom_range(1) != 0) ? 8'h61 : 8'h41;
		if (d < 4'd10)
			return 8'h30 + {4'd0, d};
		return base + {4'd0, d} - 8'd10;
	endfunction

	function automatic logic [7:0] rand_hex();
		return HEXCH[$urandom_range(21)];
	endfunction

	// one string of 1..5 tokens, mostly well-formed escapes
	task automatic build_string();
		int          ntok;
		int          kind;
		int          nx;
		logic [23:0] v;
		ntok = $urandom_range(5, 1);
		for (int t = 0; t < ntok; t++) begin
			kind = $urandom_range(99);
			if (kind < 30) begin
				str_buf.push_back(8'($urandom_range(255)));
			end else if (kind < 50) begin
				str_buf.push_back(jsu_pkg::BACKSLASH);
				str_buf.push_back(ESCCH[$urandom_range(11)]);
			end else if (kind < 58) begin
				str_buf.push_back(jsu_pkg::BACKSLASH);
				str_buf.push_back(8'($urandom_range(255)));
			end else if (kind < 78) begin
				str_buf.push_back(jsu_pkg::BACKSLASH);
				str_buf.push_back(jsu_pkg::CH_U);
				repeat (4) str_buf.push_back(rand_hex());
				nx = $urandom_range(2);
				repeat (nx) str_buf.push_back($urandom_range(1) ? rand_hex() :
					8'($urandom_range(255)));
			end else if (kind < 90) begin
				v = 24'($urandom_range(24'h01F660, 24'h01F2F0));
				str_buf.push_back(jsu_pkg::BACKSLASH);
				str_buf.push_back(jsu_pkg::CH_U);
				for (int d = 5; d >= 0; d--)
					str_buf.push_back(hex_of(v[d*4 +: 4]));
			end else if (kind < 96) begin
				str_buf.push_back(jsu_pkg::BACKSLASH);
				str_buf.push_back(jsu_pkg::CH_U);
				repeat (4) str_buf.push_back(8'($urandom_range(255)));
			end else begin
				// truncated \u escape closes the string
				str_buf.push_back(jsu_pkg::BACKSLASH);
				str_buf.push_back(jsu_pkg::CH_U);
				nx = $urandom_range(3);
				repeat (nx) str_buf.push_back(rand_hex());
				break;
			end
		end
	endtask

	initial begin
		bit ue_plan [8];
		int sent;
		ue_plan = '{1, 0, 1, 1, 0, 1, 1, 1};
		sb = new;
		text.valid          <= 1'b0;
		text.in_byte        <= 8'h00;
		text.in_last        <= 1'b0;
		cfg.valid           <= 1'b0;
		cfg.unicode_escapes <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unicode decoding off after reset
		send_text("\\u");
		send_text("\\");
		str_buf.push_back(8'h00);
		str_buf.push_back(8'hFF);
		send_buf();

		set_unicode(1'b1);
		send_text("\\u01F600");
		send_text("\\uzz~G");
		send_text("\\uab");
		send_text("\\u");

		for (int p = 0; p < 8; p++) begin
			set_unicode(ue_plan[p]);
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 86; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 86; end
				default: begin gap_pct = 33; stall_pct = 33; end
			endcase
			sent = 0;
			while (sent < 32) begin
				build_string();
				sent += str_buf.size();
				send_buf();
			end
		end

		drain();
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
